FILE: hdl/wrls_pkg.sv
// Shared types and constants of the word RAM load/store unit.
// Depends on nothing; the front, back and top-level files refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package wrls_pkg;

	// Fixed field widths of one access
	localparam int unsigned ADDR_W = 12;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned IDX_W = ADDR_W - 2;

	// Word index reduction: multiply by a scaled reciprocal, then one correction
	localparam int unsigned RECIP_SHIFT = 20;
	localparam int unsigned RECIP_W = RECIP_SHIFT + 1;

	// Depth of the queue between the front and the back
	localparam int unsigned QUEUE_DEPTH = 4;

	// Access kinds
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STORE = 1'b1;

	// Width codes (funct3)
	localparam logic [2:0] WC_BYTE = 3'd0;
	localparam logic [2:0] WC_HALF = 3'd1;
	localparam logic [2:0] WC_WORD = 3'd2;
	localparam logic [2:0] WC_BYTE_U = 3'd4;
	localparam logic [2:0] WC_HALF_U = 3'd5;

	// Access size as held in the low two bits of a legal width code
	localparam logic [1:0] SZ_HALF = 2'b01;
	localparam logic [1:0] SZ_WORD = 2'b10;

	// Lane masks
	localparam logic [DATA_W-1:0] MASK_BYTE = 32'h0000_00FF;
	localparam logic [DATA_W-1:0] MASK_HALF = 32'h0000_FFFF;

	typedef enum logic [1:0] {
		FAULT_NONE = 2'd0,
		FAULT_LOAD_MISALIGN = 2'd1,
		FAULT_STORE_MISALIGN = 2'd2,
		FAULT_ILLEGAL = 2'd3
	} fault_t;

	// One classified access as it travels from the front to the back
	typedef struct packed {
		logic op;
		logic [2:0] width_code;
		logic [1:0] offset;
		fault_t fault;
		logic [DATA_W-1:0] write_data;
	} cmd_t;

endpackage

`default_nettype wire

FILE: hdl/wrls_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing. A read of the address being written returns the old word.
`timescale 1ns / 1ps
`default_nettype none

module wrls_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/wrls_front.sv
// Front of the load/store unit: accepts items, checks width code and alignment,
// and reduces the word index modulo the RAM depth. Depends on wrls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wrls_front #(
	parameter int unsigned WORD_COUNT = 1024,
	localparam int unsigned AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	// Incoming items
	input wire logic in_valid,
	output logic in_ready,
	input wire logic op,
	input wire logic [2:0] width_code,
	input wire logic [wrls_pkg::ADDR_W-1:0] byte_addr,
	input wire logic [wrls_pkg::DATA_W-1:0] write_data,
	// Towards the queue
	output logic push,
	input wire logic queue_full,
	output wrls_pkg::cmd_t push_cmd,
	output logic [AW-1:0] push_idx
);

	localparam int unsigned IdxW = wrls_pkg::IDX_W;
	localparam int unsigned RecipW = wrls_pkg::RECIP_W;
	localparam int unsigned ProdW = IdxW + RecipW;
	localparam int unsigned QuotW = ProdW - wrls_pkg::RECIP_SHIFT;
	localparam logic [RecipW-1:0] RecipM =
		RecipW'((33'd1 << wrls_pkg::RECIP_SHIFT) / WORD_COUNT);
	localparam logic [31:0] WordCnt = 32'(WORD_COUNT);

	logic legal;
	logic misaligned;
	wrls_pkg::cmd_t cmd_d;
	logic [IdxW-1:0] word_idx;
	logic [ProdW-1:0] prod_d;

	logic valid_s1;
	logic valid_s2;
	wrls_pkg::cmd_t cmd_s1;
	wrls_pkg::cmd_t cmd_s2;
	logic [IdxW-1:0] idx_s1;
	logic [ProdW-1:0] prod_s1;
	logic [AW-1:0] idx_s2;

	logic [QuotW-1:0] quot;
	logic [31:0] quot_x_cnt;
	logic [31:0] rem_raw;
	logic [31:0] rem_fix;

	logic adv_s1;
	logic s2_free;

	// Classify the access: legality first, then alignment
	always_comb begin
		legal = 1'b0;
		if (width_code inside {wrls_pkg::WC_BYTE, wrls_pkg::WC_HALF, wrls_pkg::WC_WORD}) begin
			legal = 1'b1;
		end else if (width_code inside {wrls_pkg::WC_BYTE_U, wrls_pkg::WC_HALF_U}) begin
			legal = (op == wrls_pkg::OP_LOAD);
		end
		misaligned = ((width_code[1:0] == wrls_pkg::SZ_HALF) && byte_addr[0])
			|| ((width_code[1:0] == wrls_pkg::SZ_WORD) && (byte_addr[1:0] != 2'b00));
		cmd_d.op = op;
		cmd_d.width_code = width_code;
		cmd_d.offset = byte_addr[1:0];
		cmd_d.write_data = write_data;
		if (!legal) begin
			cmd_d.fault = wrls_pkg::FAULT_ILLEGAL;
		end else if (misaligned) begin
			cmd_d.fault = (op == wrls_pkg::OP_STORE) ? wrls_pkg::FAULT_STORE_MISALIGN
				: wrls_pkg::FAULT_LOAD_MISALIGN;
		end else begin
			cmd_d.fault = wrls_pkg::FAULT_NONE;
		end
	end

	// Estimated quotient of the word index by the depth, by reciprocal
	assign word_idx = byte_addr[wrls_pkg::ADDR_W-1:2];
	assign prod_d = ProdW'(word_idx) * ProdW'(RecipM);

	// Remainder with one correction step; the estimate is low by at most one
	always_comb begin
		quot = prod_s1[ProdW-1:wrls_pkg::RECIP_SHIFT];
		quot_x_cnt = 32'(quot) * WordCnt;
		rem_raw = 32'(idx_s1) - quot_x_cnt;
		rem_fix = (rem_raw >= WordCnt) ? (rem_raw - WordCnt) : rem_raw;
	end

	// Handshake of the two front stages
	assign push = valid_s2 && !queue_full;
	assign s2_free = !valid_s2 || push;
	assign adv_s1 = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload of the two front stages
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_d;
			idx_s1 <= word_idx;
			prod_s1 <= prod_d;
		end
		if (adv_s1) begin
			cmd_s2 <= cmd_s1;
			idx_s2 <= AW'(rem_fix);
		end
	end

	assign push_cmd = cmd_s2;
	assign push_idx = idx_s2;

	// The reduced index always lies inside the RAM.
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (32'(idx_s2) < WordCnt))
		else $error("word index outside the RAM");

	// A load misalignment is only ever reported for a load.
	a_load_fault_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (cmd_s2.fault == wrls_pkg::FAULT_LOAD_MISALIGN))
		|-> (cmd_s2.op == wrls_pkg::OP_LOAD))
		else $error("load misalignment on a store");

endmodule

`default_nettype wire

FILE: hdl/wrls_fifo.sv
// Short first-in first-out queue between the front and the back.
// Depends on nothing; the payload is an opaque vector.
`timescale 1ns / 1ps
`default_nettype none

module wrls_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] push_data,
	output logic full,
	input wire logic pop,
	output logic valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	logic [WIDTH-1:0] slot_q [0:DEPTH-1];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full = (count_q == FullCnt);
	assign valid = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/wrls_back.sv
// Back of the load/store unit: reads the RAM, merges stores, extends loads and
// holds the result in the output register. Depends on wrls_pkg and wrls_ram.
`timescale 1ns / 1ps
`default_nettype none

module wrls_back #(
	parameter int unsigned WORD_COUNT = 1024,
	localparam int unsigned AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	// From the queue
	input wire logic q_valid,
	output logic q_pop,
	input wire wrls_pkg::cmd_t q_cmd,
	input wire logic [AW-1:0] q_idx,
	// Result items
	output logic res_valid,
	input wire logic res_ready,
	output logic [wrls_pkg::DATA_W-1:0] read_data,
	output wrls_pkg::fault_t fault
);

	localparam int unsigned DW = wrls_pkg::DATA_W;

	logic acc_valid_s1;
	wrls_pkg::cmd_t cmd_s1;
	logic [AW-1:0] idx_s1;

	logic res_valid_q;
	logic [DW-1:0] res_data_q;
	wrls_pkg::fault_t res_fault_q;

	logic fwd_valid_q;
	logic [AW-1:0] fwd_idx_q;
	logic [DW-1:0] fwd_word_q;

	logic out_free;
	logic adv_s1;
	logic ram_we;
	logic [DW-1:0] ram_rdata;
	logic [DW-1:0] word;
	logic [4:0] shamt;
	logic [DW-1:0] lane;
	logic [DW-1:0] load_val;
	logic [DW-1:0] lane_mask;
	logic [DW-1:0] merged;

	// Flow control: the access stage moves on when the output register frees
	assign out_free = !res_valid_q || res_ready;
	assign adv_s1 = acc_valid_s1 && out_free;
	assign q_pop = q_valid && (!acc_valid_s1 || adv_s1);
	assign ram_we = adv_s1 && (cmd_s1.op == wrls_pkg::OP_STORE)
		&& (cmd_s1.fault == wrls_pkg::FAULT_NONE);

	wrls_ram #(
		.WIDTH(DW),
		.DEPTH(WORD_COUNT)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(idx_s1),
		.wdata(merged),
		.re(q_pop),
		.raddr(q_idx),
		.rdata(ram_rdata)
	);

	// The word read may miss the store retired in the same cycle; take it from
	// the bypass register, which always holds the latest word written.
	always_comb begin
		word = (fwd_valid_q && (fwd_idx_q == idx_s1)) ? fwd_word_q : ram_rdata;
		shamt = {cmd_s1.offset, 3'b000};
		lane = word >> shamt;
	end

	// Load extension
	always_comb begin
		case (cmd_s1.width_code)
			wrls_pkg::WC_BYTE: load_val = {{(DW-8){lane[7]}}, lane[7:0]};
			wrls_pkg::WC_HALF: load_val = {{(DW-16){lane[15]}}, lane[15:0]};
			wrls_pkg::WC_BYTE_U: load_val = lane & wrls_pkg::MASK_BYTE;
			wrls_pkg::WC_HALF_U: load_val = lane & wrls_pkg::MASK_HALF;
			default: load_val = word;
		endcase
	end

	// Store merge into the addressed lane
	always_comb begin
		lane_mask = (cmd_s1.width_code[1:0] == wrls_pkg::SZ_HALF) ? wrls_pkg::MASK_HALF
			: wrls_pkg::MASK_BYTE;
		if (cmd_s1.width_code[1:0] == wrls_pkg::SZ_WORD) begin
			merged = cmd_s1.write_data;
		end else begin
			merged = (word & ~(lane_mask << shamt))
				| ((cmd_s1.write_data & lane_mask) << shamt);
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				acc_valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				acc_valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (ram_we) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= q_cmd;
			idx_s1 <= q_idx;
		end
		if (ram_we) begin
			fwd_idx_q <= idx_s1;
			fwd_word_q <= merged;
		end
		if (adv_s1) begin
			res_fault_q <= cmd_s1.fault;
			res_data_q <= ((cmd_s1.op == wrls_pkg::OP_LOAD)
				&& (cmd_s1.fault == wrls_pkg::FAULT_NONE)) ? load_val : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign read_data = res_data_q;
	assign fault = res_fault_q;

	// A faulting access never returns data.
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_fault_q != wrls_pkg::FAULT_NONE)) |-> (res_data_q == '0))
		else $error("faulting access returned data");

	// Every RAM write is captured by the bypass register for the next read.
	a_bypass_follows: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (fwd_valid_q && (fwd_idx_q == $past(idx_s1))))
		else $error("bypass register missed a RAM write");

endmodule

`default_nettype wire

FILE: hdl/word_ram_load_store_unit.sv
// Top level of the word RAM load/store unit: front, queue and back.
// Depends on wrls_pkg, wrls_front, wrls_fifo and wrls_back.
//
//   Channel  Direction  Payload
//   s_*      in         tuser: op, width_code   tdata: byte_addr, write_data
//   m_*      out        tuser: fault            tdata: read_data
//
// One item is taken per cycle when neither side stalls. The accepting edge loads the
// first front stage; the item then passes through the second front stage, the queue,
// the RAM read stage and the output register, which presents its result. The RAM
// read port, one access per cycle, sets that rate.
// The RAM holds no defined contents after reset and needs no clearing.
// The four-entry queue lets the front keep accepting while the result side stalls.
`timescale 1ns / 1ps
`default_nettype none

module word_ram_load_store_unit #(
	parameter int unsigned WORD_COUNT = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [47:0] s_tdata, // byte_addr[11:0], write_data[43:12], zero pad
	input wire logic [3:0] s_tuser, // op[0], width_code[3:1]
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [31:0] m_tdata, // read_data[31:0]
	output logic [1:0] m_tuser // fault[1:0]
);

	localparam int unsigned AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int unsigned CmdW = $bits(wrls_pkg::cmd_t);
	localparam int unsigned QW = CmdW + AW;

	logic push;
	logic queue_full;
	wrls_pkg::cmd_t push_cmd;
	logic [AW-1:0] push_idx;
	logic q_valid;
	logic q_pop;
	logic [QW-1:0] q_data;
	wrls_pkg::cmd_t q_cmd;
	logic [AW-1:0] q_idx;
	wrls_pkg::fault_t res_fault;

	// Front: accept and classify
	wrls_front #(
		.WORD_COUNT(WORD_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.op(s_tuser[0]),
		.width_code(s_tuser[3:1]),
		.byte_addr(s_tdata[11:0]),
		.write_data(s_tdata[43:12]),
		.push(push),
		.queue_full(queue_full),
		.push_cmd(push_cmd),
		.push_idx(push_idx)
	);

	// Queue between the two halves
	wrls_fifo #(
		.WIDTH(QW),
		.DEPTH(wrls_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_idx, push_cmd}),
		.full(queue_full),
		.pop(q_pop),
		.valid(q_valid),
		.pop_data(q_data)
	);

	assign q_cmd = wrls_pkg::cmd_t'(q_data[CmdW-1:0]);
	assign q_idx = q_data[QW-1:CmdW];

	// Back: RAM access and result register
	wrls_back #(
		.WORD_COUNT(WORD_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_cmd(q_cmd),
		.q_idx(q_idx),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.read_data(m_tdata),
		.fault(res_fault)
	);

	assign m_tuser = res_fault;

endmodule

`default_nettype wire
